@@ rtl/core/lazy_one_shot_timer_bank_defines.svh @@
// Assertion macros used by the checker file of the timer bank.
`ifndef LAZY_ONE_SHOT_TIMER_BANK_DEFINES_SVH
`define LAZY_ONE_SHOT_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LOTS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("timer bank check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LOTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("timer bank check failed");

// Implication with a fixed delay set by the macro argument n.
`define LOTS_ASSERT_DELAY(lbl, clk, rstn, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##n (cons)) \
        else $error("timer bank check failed");

`endif

@@ rtl/core/lots_pkg.sv @@
package lots_pkg;

    // Field widths of the input and result items.
    localparam int CMD_W = 2;
    localparam int IDX_W = 4;
    localparam int DUR_W = 32;

    // Largest bank that the index field can address.
    localparam int MAX_TIMERS = 2 ** IDX_W;

    // Packed stream widths; the tdata widths are padded to whole bytes.
    localparam int IN_W      = IDX_W + DUR_W;
    localparam int RES_W     = 1 + DUR_W;
    localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_POLL = 2'd2
    } cmd_t;

endpackage

@@ rtl/core/lazy_one_shot_timer_bank.sv @@
// Channel  Direction  Payload
// -------  ---------  --------------------------------------------------------
// s_*      input      tuser: command; tdata: timer_index, duration
// m_*      output     tdata: expired, remaining (one result per input item)
//
// One item per cycle is taken while nothing stalls. The addressed timer is read,
// updated and written back at the edge that moves it from the input register to the
// result register once that register is free or drains; m_tvalid then offers it.
// Reset (rst_n low, asynchronous) empties both registers, clears the tick count
// and leaves every timer expired with zero remaining. A stall on the result side
// holds the result register and lowers s_tready once the input register is full.
module lazy_one_shot_timer_bank #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata, lowest bit up: timer_index[3:0], duration[35:4], zero padding.
    input  logic [lots_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser, lowest bit up: command[1:0].
    input  logic [lots_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata, lowest bit up: expired[0], remaining[32:1], zero padding.
    output logic [lots_pkg::M_TDATA_W-1:0] m_tdata
);
    import lots_pkg::*;

    // Only the timers that the index field can reach are stored.
    localparam int DEPTH = (NUM_TIMERS < MAX_TIMERS) ? NUM_TIMERS : MAX_TIMERS;
    localparam int ENT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Input register.
    logic             in_vld_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [DUR_W-1:0] dur_reg;

    // Result register.
    logic             out_vld_reg;
    logic             res_exp_reg;
    logic [DUR_W-1:0] res_rem_reg;

    // Timer state, one flip-flop entry per timer.
    logic [DUR_W-1:0] now_reg;
    logic             exp_reg  [DEPTH];
    logic [DUR_W-1:0] rem_reg  [DEPTH];
    logic [DUR_W-1:0] last_reg [DEPTH];

    logic             adv;
    logic             in_range;
    logic [ENT_W-1:0] sel;
    logic             ent_exp;
    logic [DUR_W-1:0] ent_rem;
    logic [DUR_W-1:0] ent_last;
    logic [DUR_W-1:0] span;
    logic [DUR_W-1:0] now_next;
    logic             wr_en;
    logic             exp_next;
    logic [DUR_W-1:0] rem_next;
    logic [DUR_W-1:0] last_next;
    logic             res_exp_next;
    logic [DUR_W-1:0] res_rem_next;

    // The held item is processed whenever the result register is free or drains.
    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;

    assign in_range = (32'(idx_reg) < 32'(NUM_TIMERS));
    assign sel      = idx_reg[ENT_W-1:0];
    assign ent_exp  = exp_reg[sel];
    assign ent_rem  = rem_reg[sel];
    assign ent_last = last_reg[sel];
    // The tick count wraps, so the span is taken modulo 2^32.
    assign span     = now_reg - ent_last;

    always_comb
    begin
        now_next     = now_reg;
        wr_en        = 1'b0;
        exp_next     = ent_exp;
        rem_next     = ent_rem;
        last_next    = ent_last;
        res_exp_next = 1'b0;
        res_rem_next = '0;
        unique case (cmd_t'(cmd_reg))
            CMD_TICK:
            begin
                now_next = now_reg + 32'd1;
            end
            CMD_SET:
            begin
                // A set beyond the bank is dropped. Zero duration arms as expired.
                if (in_range)
                begin
                    wr_en     = 1'b1;
                    exp_next  = (dur_reg == '0);
                    rem_next  = dur_reg;
                    last_next = now_reg;
                end
            end
            CMD_POLL:
            begin
                // A poll beyond the bank reports zeros and changes nothing.
                if (in_range)
                begin
                    if (ent_exp)
                    begin
                        res_exp_next = 1'b1;
                        res_rem_next = ent_rem;
                    end
                    else if (ent_rem == '0)
                    begin
                        // An armed timer holding zero expires without touching its stamp.
                        wr_en        = 1'b1;
                        exp_next     = 1'b1;
                        res_exp_next = 1'b1;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        last_next = now_reg;
                        if (span >= ent_rem)
                        begin
                            rem_next     = '0;
                            exp_next     = 1'b1;
                            res_exp_next = 1'b1;
                        end
                        else
                        begin
                            rem_next     = ent_rem - span;
                            res_rem_next = ent_rem - span;
                        end
                    end
                end
            end
            default:
            begin
                // The unused command code changes nothing and reports zeros.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (!out_vld_reg || m_tready)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser[CMD_W-1:0];
            idx_reg <= s_tdata[IDX_W-1:0];
            dur_reg <= s_tdata[IN_W-1:IDX_W];
        end
        if (adv)
        begin
            res_exp_reg <= res_exp_next;
            res_rem_reg <= res_rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                exp_reg[i]  <= 1'b1;
                rem_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            now_reg <= now_next;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (wr_en && (sel == ENT_W'(i)))
                begin
                    exp_reg[i]  <= exp_next;
                    rem_reg[i]  <= rem_next;
                    last_reg[i] <= last_next;
                end
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, res_rem_reg, res_exp_reg};

endmodule

@@ rtl/core/lots_checker.sv @@
`include "lazy_one_shot_timer_bank_defines.svh"

module lots_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lots_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [lots_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lots_pkg::M_TDATA_W-1:0] m_tdata
);
    import lots_pkg::*;

    logic s_xfer;
    logic m_stall;
    logic bad_report;
    logic pad_set;

    assign s_xfer     = s_tvalid && s_tready;
    assign m_stall    = m_tvalid && !m_tready;
    // An expired timer always reports zero remaining time.
    assign bad_report = m_tdata[0] && (m_tdata[RES_W-1:1] != '0);
    assign pad_set    = (m_tdata[M_TDATA_W-1:RES_W] != '0);

    // A stalled result holds its place and its value.
    `LOTS_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_stall, m_tvalid && $stable(m_tdata))
    // A transfer in is followed by a valid result once it has passed the input and result registers.
    `LOTS_ASSERT_DELAY(a_result_due, clk, rst_n, s_xfer, 2, m_tvalid)
    `LOTS_ASSERT_NOW(a_expired_zero, clk, rst_n, m_tvalid, !bad_report)
    `LOTS_ASSERT_NOW(a_pad_zero, clk, rst_n, m_tvalid, !pad_set)

endmodule

bind lazy_one_shot_timer_bank lots_checker u_lots_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/poll_report_checker.sv @@
module poll_report_checker #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [lots_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [lots_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lots_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             mismatch_count,
    output int                             open_reports
);

    timeunit 1ns;
    timeprecision 1ps;

    import lots_pkg::*;

    typedef struct packed {
        logic             expired;
        logic [DUR_W-1:0] remaining;
    } poll_report_t;

    // Shadow copy of the bank.
    logic [DUR_W-1:0] tick_count;
    logic             timer_expired [NUM_TIMERS];
    logic [DUR_W-1:0] timer_left    [NUM_TIMERS];
    logic [DUR_W-1:0] timer_stamp   [NUM_TIMERS];

    poll_report_t     report_q [$];
    poll_report_t     want;
    poll_report_t     got;
    logic [CMD_W-1:0] in_cmd;
    logic [IDX_W-1:0] in_idx;
    logic [DUR_W-1:0] in_dur;
    logic [DUR_W-1:0] span;
    int               i;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count = '0;
            for (i = 0; i < NUM_TIMERS; i++)
            begin
                timer_expired[i] = 1'b1;
                timer_left[i]    = '0;
                timer_stamp[i]   = '0;
            end
            report_q.delete();
            mismatch_count = 0;
            open_reports   = 0;
        end
        else
        begin
            // A result leaves only after its input has passed the input register and the
            // result register, so the result side is handled first.
            if (m_tvalid && m_tready)
            begin
                got.expired   = m_tdata[0];
                got.remaining = m_tdata[DUR_W:1];
                if (report_q.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display({"%0t: result transfer with nothing expected: ",
                                  "expired=%0b remaining=%0d"},
                                 $realtime, got.expired, got.remaining);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (got.expired !== want.expired || got.remaining !== want.remaining)
                    begin
                        if (mismatch_count < 10)
                            $display({"%0t: report mismatch: expected expired=%0b ",
                                      "remaining=%0d, got expired=%0b remaining=%0d"},
                                     $realtime, want.expired, want.remaining,
                                     got.expired, got.remaining);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                in_cmd = s_tuser[CMD_W-1:0];
                in_idx = s_tdata[IDX_W-1:0];
                in_dur = s_tdata[IDX_W +: DUR_W];
                want   = '0;
                case (in_cmd)
                    CMD_TICK:
                        tick_count = tick_count + 1'b1;
                    CMD_SET:
                        if (in_idx < NUM_TIMERS)
                        begin
                            timer_expired[in_idx] = (in_dur == '0);
                            timer_left[in_idx]    = in_dur;
                            timer_stamp[in_idx]   = tick_count;
                        end
                    CMD_POLL:
                        if (in_idx < NUM_TIMERS)
                        begin
                            // An expired timer is reported as it stands.
                            if (!timer_expired[in_idx])
                            begin
                                if (timer_left[in_idx] == '0)
                                    timer_expired[in_idx] = 1'b1;
                                else
                                begin
                                    span = tick_count - timer_stamp[in_idx];
                                    timer_stamp[in_idx] = tick_count;
                                    if (span >= timer_left[in_idx])
                                    begin
                                        timer_left[in_idx]    = '0;
                                        timer_expired[in_idx] = 1'b1;
                                    end
                                    else
                                        timer_left[in_idx] = timer_left[in_idx] - span;
                                end
                            end
                            want.expired   = timer_expired[in_idx];
                            want.remaining = timer_left[in_idx];
                        end
                    default:
                        ;
                endcase
                report_q.push_back(want);
            end
            open_reports = report_q.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lots_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 7;
    localparam int NUM_TIMERS     = 16;
    localparam int RANDOM_ITEMS   = 750;
    localparam int IDLE_PERCENT   = 29;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 200000;

    // The command field has one code that the package leaves unnamed.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [DUR_W-1:0] DUR_MAX    = '1;
    localparam logic [IDX_W-1:0] IDX_MAX    = '1;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int open_reports;
    int cycle_count = 0;

    // While idle_enable is low neither side inserts random idle cycles.
    bit idle_enable     = 1'b1;
    // A request from the stimulus for one long stall on the result side.
    bit holdoff_request = 1'b0;

    lazy_one_shot_timer_bank #(
        .NUM_TIMERS (NUM_TIMERS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // The checker watches both channels, predicts every report and
    // compares; this module only makes traffic and gives the verdict.
    poll_report_checker #(
        .NUM_TIMERS (NUM_TIMERS)
    ) report_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .open_reports   (open_reports)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog. A run that hangs ends here with a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[lazy_one_shot_timer_bank] ERROR");
        $finish;
    end

    // Result side. Ready changes only at the falling edge. A hold-off holds
    // ready low while it counts falling edges here, so that both pipeline
    // registers fill and the block stops taking input.
    initial
    begin : result_side
        int held;
        forever
        begin
            @(negedge clk);
            if (holdoff_request)
            begin
                m_tready <= 1'b0;
                holdoff_request = 1'b0;
                for (held = 0; held < HOLDOFF_CYCLES; held++)
                    @(negedge clk);
            end
            else
                m_tready <= !(idle_enable && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Offers one item and returns at the falling edge after its transfer.
    // Random idle cycles go in front of the item. Valid gets at most one
    // assignment per falling edge, so back-to-back items keep it high.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [DUR_W-1:0] dur);
        logic [S_TDATA_W-1:0] word;
        word                 = '0;
        word[IDX_W-1:0]      = idx;
        word[IDX_W +: DUR_W] = dur;
        if (idle_enable && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while (idle_enable && $urandom_range(99) < IDLE_PERCENT)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Drops valid and waits at falling edges until every expected report
    // has come back. The first wait keeps valid from being lowered and
    // raised in the same step.
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (open_reports != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                n;
        int                pick;
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  idx;
        logic [DUR_W-1:0]  dur;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Timers come out of reset expired with nothing left.
        send_item(CMD_POLL, '0, '0);
        send_item(CMD_POLL, IDX_MAX, DUR_MAX);
        // A zero duration leaves the timer expired at once.
        send_item(CMD_SET, '0, '0);
        send_item(CMD_POLL, '0, '0);
        // The largest duration on the last timer, then a poll with no time gone.
        send_item(CMD_SET, IDX_MAX, DUR_MAX);
        send_item(CMD_POLL, IDX_MAX, '0);
        // A tick ignores its index and duration, even when they are all ones.
        send_item(CMD_TICK, IDX_MAX, DUR_MAX);
        send_item(CMD_POLL, IDX_MAX, DUR_MAX);
        // Count down in steps, and past the end.
        send_item(CMD_SET, 4'd3, 32'd2);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_POLL, 4'd3, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_POLL, 4'd3, '0);
        // The span lands exactly on the remaining time.
        send_item(CMD_SET, 4'd5, 32'd3);
        send_item(CMD_TICK, 4'd5, 32'd3);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_POLL, 4'd5, '0);
        // Polling an expired timer again changes nothing.
        send_item(CMD_POLL, 4'd5, DUR_MAX);
        // The unused command code reports zeros and leaves the bank alone.
        send_item(CMD_UNUSED, IDX_MAX, DUR_MAX);
        send_item(CMD_SET, 4'd7, 32'd1);
        send_item(CMD_POLL, 4'd7, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_POLL, 4'd7, '0);

        // The sender pauses until every expected report has come.
        wait_until_drained();

        // Random part. Most durations are short so that timers run out
        // within the run; a few are zero or full width.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_enable = !(n >= 250 && n < 400);
            if (n == 500)
                holdoff_request = 1'b1;
            if (n == 620)
                wait_until_drained();

            pick = $urandom_range(99);
            if (pick < 38)
                cmd = CMD_TICK;
            else if (pick < 63)
                cmd = CMD_SET;
            else if (pick < 95)
                cmd = CMD_POLL;
            else
                cmd = CMD_UNUSED;

            idx  = IDX_W'($urandom_range(NUM_TIMERS - 1));
            pick = $urandom_range(9);
            if (pick == 0)
                dur = '0;
            else if (pick < 3)
                dur = $urandom;
            else
                dur = $urandom_range(24, 1);
            send_item(cmd, idx, dur);
        end

        // Wait for the last reports, then keep the run going, so that a stray
        // extra result transfer would still be seen.
        idle_enable = 1'b1;
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[lazy_one_shot_timer_bank] OK");
        else
            $display("[lazy_one_shot_timer_bank] ERROR");
        $finish;
    end

endmodule
